// ===== rtl/arccos_poly_approx_core_defines.svh =====
// assertion macros for the arccos approximation core
`ifndef ARCCOS_POLY_APPROX_CORE_DEFINES_SVH
`define ARCCOS_POLY_APPROX_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define APA_ASSERT_NOW(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("arccos core assertion failed");

// next-cycle implication, disabled while in reset
`define APA_ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("arccos core assertion failed");

`endif

// ===== rtl/apa_pkg.sv =====
// shared constants, widths and rounding helper for the arccos core
`default_nettype none

package apa_pkg;

	// internal fixed point: unsigned, 30 fraction bits
	localparam int IW  = 30;
	localparam int AW  = IW + 1;       // |x| and 1 - |x|, up to 1.0
	localparam int RW  = AW + 3;       // square root partial remainder
	localparam int SQ_STEPS = 32;      // root bits resolved, one per stage
	localparam int NW  = 2 * SQ_STEPS; // radicand width
	localparam int C0W = 25;
	localparam int T1W = 27;
	localparam int T2W = 28;
	localparam int T3W = 31;
	localparam int QW  = 34;           // rounded product width
	localparam int PW  = 32;           // angle before output rounding

	localparam logic [C0W-1:0] K_C0 = 25'd20110433;
	localparam logic [T1W-1:0] K_C1 = 27'd79737142;
	localparam logic [T2W-1:0] K_C2 = 28'd227756103;
	localparam logic [T3W-1:0] K_C3 = 31'd1686557207;
	localparam logic [PW-1:0]  K_PI = 32'd3373259426;

	localparam logic [AW-1:0] ONE_INT  = AW'(1) << IW;
	localparam logic [63:0]   HALF_INT = 64'd1 << (IW - 1);

	// product back to 30 fraction bits, nearest, ties up
	function automatic logic [QW-1:0] qrnd(input logic [63:0] p);
		logic [63:0] s;
		s = (p + HALF_INT) >> IW;
		return s[QW-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/apa_isqrt.sv =====
// pipelined integer square root of (1 - |x|) scaled by 2^30, one root bit per stage
`default_nettype none

module apa_isqrt import apa_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [AW-1:0] in_m,
	output logic               out_valid,
	output logic [AW-1:0]      out_root
);

	logic          v_s    [SQ_STEPS];
	logic [AW-1:0] m_s    [SQ_STEPS-1];
	logic [RW-1:0] rem_s  [SQ_STEPS-1];
	logic [AW-1:0] root_s [SQ_STEPS];

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
		logic          v_i;
		logic [AW-1:0] m_i;
		logic [RW-1:0] rem_i;
		logic [AW-1:0] root_i;
		logic [NW-1:0] n;
		logic [1:0]    n2;
		logic [RW-1:0] rsh;
		logic [RW-1:0] trial;
		logic          ge;

		if (j == 0) begin : g_first
			assign v_i    = in_valid;
			assign m_i    = in_m;
			assign rem_i  = '0;
			assign root_i = '0;
		end else begin : g_rest
			assign v_i    = v_s[j-1];
			assign m_i    = m_s[j-1];
			assign rem_i  = rem_s[j-1];
			assign root_i = root_s[j-1];
		end

		// radicand is (1 - a) shifted up by 30, bring down two bits per step
		assign n     = {{(NW - AW - IW){1'b0}}, m_i, {IW{1'b0}}};
		assign n2    = n[NW-1-2*j -: 2];
		assign rsh   = {rem_i[RW-3:0], n2};
		assign trial = RW'({root_i, 2'b01});
		assign ge    = (rsh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[j] <= {root_i[AW-2:0], ge};
			end
		end

		if (j < SQ_STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					m_s[j]   <= m_i;
					rem_s[j] <= ge ? (rsh - trial) : rsh;
				end
			end
		end
	end

	assign out_valid = v_s[SQ_STEPS-1];
	assign out_root  = root_s[SQ_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/arccos_poly_approx_core.sv =====
// arccos core: cubic polynomial in |x| times sqrt(1 - |x|), reflected for negative x
// one word per cycle sustained while the output is not held
// the 32-stage root pipeline sets the depth; the polynomial runs beside it and is delayed
// a one-word input skid keeps in_ready registered, so a word is taken while a result waits
// reset clears the valid bits and the skid; payload registers are not reset
`default_nettype none

module arccos_poly_approx_core import apa_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [FRAC_BITS+1:0]   x_value,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [FRAC_BITS+1:0]        angle
);

	localparam int XW   = FRAC_BITS + 2;
	localparam int MAGW = FRAC_BITS + 1;
	localparam int SH   = IW - FRAC_BITS;
	localparam int DLY  = SQ_STEPS + 1 - 7;
	localparam logic [XW-1:0] ONE_IN   = XW'(1) << FRAC_BITS;
	localparam logic [PW:0]   HALF_OUT = (PW + 1)'((64'd1 << SH) >> 1);

	logic          adv;
	logic          skid_v_q;
	logic [XW-1:0] skid_x_q;
	logic          src_v;
	logic [XW-1:0] src_x;

	// stall the whole pipe only when the output word is held
	assign adv      = !out_valid || out_ready;
	assign in_ready = !skid_v_q;
	assign src_v    = skid_v_q || in_valid;
	assign src_x    = skid_v_q ? skid_x_q : x_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (adv) begin
			skid_v_q <= 1'b0;
		end else if (in_valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && in_valid && !skid_v_q) begin
			skid_x_q <= x_value;
		end
	end

	// stage 1: magnitude, saturate to 1.0, scale to 30 fraction bits, form 1 - a
	logic            neg_c;
	logic [XW-1:0]   mag_c;
	logic [MAGW-1:0] magc_c;
	logic [AW-1:0]   a_c;

	assign neg_c  = src_x[XW-1];
	assign mag_c  = neg_c ? (~src_x + XW'(1)) : src_x;
	assign magc_c = (mag_c > ONE_IN) ? ONE_IN[MAGW-1:0] : mag_c[MAGW-1:0];
	assign a_c    = AW'(magc_c) << SH;

	logic          v_s1;
	logic          neg_s1;
	logic [AW-1:0] a_s1;
	logic [AW-1:0] m_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= src_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1 <= neg_c;
			a_s1   <= a_c;
			m_s1   <= ONE_INT - a_c;
		end
	end

	// square root of (1 - a), stages 2 to 33
	logic          v_s33;
	logic [AW-1:0] root_s33;

	apa_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s1),
		.in_m     (m_s1),
		.out_valid(v_s33),
		.out_root (root_s33)
	);

	// polynomial by Horner, stages 2 to 7
	logic [C0W+AW-1:0] p0_s2;
	logic [T1W+AW-1:0] p1_s4;
	logic [T2W+AW-1:0] p2_s6;
	logic [T1W-1:0]    t1_s3;
	logic [T2W-1:0]    t2_s5;
	logic [T3W-1:0]    t3_s7;
	logic [AW-1:0]     a_s2, a_s3, a_s4, a_s5;
	logic              neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [QW-1:0]     q0_c, q1_c, q2_c;

	assign q0_c = qrnd(64'(p0_s2));
	assign q1_c = qrnd(64'(p1_s4));
	assign q2_c = qrnd(64'(p2_s6));

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s2  <= (C0W + AW)'(K_C0) * (C0W + AW)'(a_s1);
			a_s2   <= a_s1;
			neg_s2 <= neg_s1;
			t1_s3  <= K_C1 - q0_c[T1W-1:0];
			a_s3   <= a_s2;
			neg_s3 <= neg_s2;
			p1_s4  <= (T1W + AW)'(t1_s3) * (T1W + AW)'(a_s3);
			a_s4   <= a_s3;
			neg_s4 <= neg_s3;
			// magnitude of the negative middle term
			t2_s5  <= K_C2 - q1_c[T2W-1:0];
			a_s5   <= a_s4;
			neg_s5 <= neg_s4;
			p2_s6  <= (T2W + AW)'(t2_s5) * (T2W + AW)'(a_s5);
			neg_s6 <= neg_s5;
			t3_s7  <= K_C3 - q2_c[T3W-1:0];
			neg_s7 <= neg_s6;
		end
	end

	// line up the polynomial with the root, stages 8 to 33
	logic [T3W:0] dly_s [DLY];

	always_ff @(posedge clk) begin
		if (adv) begin
			dly_s[0] <= {neg_s7, t3_s7};
			for (int i = 1; i < DLY; i++) begin
				dly_s[i] <= dly_s[i-1];
			end
		end
	end

	// stages 34 to 36: product, clamp and reflect, output rounding
	logic              v_s34, v_s35, v_s36;
	logic [T3W+AW-1:0] prod_s34;
	logic              neg_s34;
	logic [PW-1:0]     r_s35;
	logic [XW-1:0]     angle_s36;
	logic [QW-1:0]     qr_c;
	logic [PW-1:0]     rc_c;
	logic [PW-1:0]     rr_c;
	logic [PW:0]       ro_c;

	assign qr_c = qrnd(64'(prod_s34));
	assign rc_c = (qr_c > QW'(K_PI)) ? K_PI : qr_c[PW-1:0];
	assign rr_c = neg_s34 ? (K_PI - rc_c) : rc_c;
	assign ro_c = ({1'b0, r_s35} + HALF_OUT) >> SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s34 <= 1'b0;
			v_s35 <= 1'b0;
			v_s36 <= 1'b0;
		end else if (adv) begin
			v_s34 <= v_s33;
			v_s35 <= v_s34;
			v_s36 <= v_s35;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s34  <= (T3W + AW)'(dly_s[DLY-1][T3W-1:0]) * (T3W + AW)'(root_s33);
			neg_s34   <= dly_s[DLY-1][T3W];
			r_s35     <= rr_c;
			angle_s36 <= ro_c[XW-1:0];
		end
	end

	assign out_valid = v_s36;
	assign angle     = angle_s36;

endmodule

`default_nettype wire

// ===== rtl/apa_checker.sv =====
// port-level checks for the arccos core, bound to the top level
`default_nettype none
`include "arccos_poly_approx_core_defines.svh"

module apa_checker import apa_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic [FRAC_BITS+1:0] x_value,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [FRAC_BITS+1:0] angle
);

	localparam int XW = FRAC_BITS + 2;
	localparam int SH = IW - FRAC_BITS;
	localparam logic [PW:0]   HALF_OUT = (PW + 1)'((64'd1 << SH) >> 1);
	localparam logic [PW:0]   PI_SUM   = {1'b0, K_PI} + HALF_OUT;
	localparam logic [PW:0]   PI_SH    = PI_SUM >> SH;
	localparam logic [XW-1:0] PI_OUT   = PI_SH[XW-1:0];

	logic in_seen;
	assign in_seen = in_valid && (x_value == x_value);

	// out_ready lets the whole pipe advance, which empties the skid and raises in_ready again
	`APA_ASSERT_NEXT(a_ready_returns, clk, arst_n, out_ready, in_ready)

	// input can only be refused while a result sits at the output
	`APA_ASSERT_NOW(a_refuse_needs_result, clk, arst_n, !in_ready, out_valid)

	// every angle lies in zero to pi
	`APA_ASSERT_NOW(a_angle_range, clk, arst_n, out_valid, angle <= PI_OUT)

	// a stalled result word holds
	`APA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(angle))

	// no result comes out of an empty core just after reset release without input
	`APA_ASSERT_NEXT(a_no_spurious, clk, arst_n, $rose(arst_n) && !in_seen, !out_valid)

endmodule

bind arccos_poly_approx_core apa_checker #(.FRAC_BITS(FRAC_BITS)) u_apa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.x_value  (x_value),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.angle    (angle)
);

`default_nettype wire
